>>> src/rlpe_pkg.sv
// Shared types and constants for the RGB LED pulse encoder.
package rlpe_pkg;

  localparam int WORD_W       = 24;
  localparam int TICK_W       = 10;
  localparam int LEDS_W       = 7;
  localparam int CNT_W        = 5;
  localparam int BITS_PER_LED = 24;
  localparam int QUEUE_DEPTH  = 2;
  localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int CFG_IDX_W    = 1;

  localparam logic [CFG_IDX_W-1:0] REG_ZERO_HIGH = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_ONE_HIGH  = 1'b1;

  localparam logic [TICK_W-1:0] ZERO_HIGH_RESET = 10'd40;
  localparam logic [TICK_W-1:0] ONE_HIGH_RESET  = 10'd79;

  // One LED to encode, with what has to come before and after it.
  typedef struct packed {
    logic [WORD_W-1:0] word;
    logic              lead;
    logic              close;
  } cmd_t;

  typedef enum logic [1:0] {
    PH_LEAD,
    PH_BITS,
    PH_TRAIL
  } phase_t;

endpackage

>>> src/rlpe_if.sv
// Handshake interfaces for the LED word input and the slot output.
interface rlpe_item_if;
  logic        valid;
  logic        ready;
  logic [23:0] led_value;
  logic        last_led;

  modport source (output valid, output led_value, output last_led, input ready);
  modport sink (input valid, input led_value, input last_led, output ready);
endinterface

interface rlpe_slot_if;
  logic       valid;
  logic       ready;
  logic [9:0] duty_ticks;
  logic       frame_end;

  modport source (output valid, output duty_ticks, output frame_end, input ready);
  modport sink (input valid, input duty_ticks, input frame_end, output ready);
endinterface

>>> src/rgb_led_pulse_encoder_unit.sv
// Top level of the RGB LED pulse encoder: front end, command queue and slot generator.
//
// Usage: in_ch takes one item per LED, a 24-bit colour word plus a mark on the
// frame's last LED. out_ch gives one item per PWM bit slot: the compare value
// (one_high_ticks for a 1 bit, zero_high_ticks for a 0 bit, most significant
// bit first, 0 for reset slots) and frame_end on the frame's final slot.
// A frame opens with RESET_SLOTS zero slots and closes with RESET_SLOTS more.
// After MAX_LEDS LEDs the frame is closed and further words are dropped up to
// and including the marked one.
// When the slot generator is idle, an accepted item is first written into the
// command queue and its first slot is then registered in the output register.
// Throughput: the slot generator emits one slot per cycle while out_ch.ready
// stays high, so an LED gives 24 slots, plus RESET_SLOTS slots per opening or closing run.
// A two-entry command queue lets the input take words while slots go out.
// Reset (rst, synchronous) empties the queue, clears the frame state and
// restores the reset values of both tick registers.
// When the receiver holds out_ch.ready low, the output register keeps its
// slot, the generator pauses and the queue fills, then in_ch.ready drops.
// Configuration is written through cfg_we, cfg_index and cfg_wdata while idle.
module rgb_led_pulse_encoder_unit import rlpe_pkg::*; #(
  parameter int MAX_LEDS    = 64,
  parameter int RESET_SLOTS = 20
) (
  input  logic                 clk,
  input  logic                 rst,
  rlpe_item_if.sink            in_ch,
  rlpe_slot_if.source          out_ch,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [TICK_W-1:0]    cfg_wdata
);

  logic [TICK_W-1:0] zero_high_ticks;
  logic [TICK_W-1:0] one_high_ticks;

  logic q_push;
  logic q_pop;
  logic q_full;
  logic q_empty;
  cmd_t push_cmd;
  cmd_t head_cmd;

  // Tick registers; the user must change them only while no slot is produced; not enforced here.
  always_ff @(posedge clk) begin
    if (rst) begin
      zero_high_ticks <= ZERO_HIGH_RESET;
      one_high_ticks  <= ONE_HIGH_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ZERO_HIGH: zero_high_ticks <= cfg_wdata;
        REG_ONE_HIGH:  one_high_ticks  <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  // The front end decides, per word, whether an opening run precedes it and
  // whether the frame closes after it; dropped words never reach the queue.
  rlpe_front #(
    .MAX_LEDS (MAX_LEDS)
  ) u_front (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .q_full (q_full),
    .push   (q_push),
    .cmd    (push_cmd)
  );

  rlpe_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_cmd (push_cmd),
    .pop      (q_pop),
    .head     (head_cmd),
    .full     (q_full),
    .empty    (q_empty)
  );

  // The back end walks each command slot by slot into the output register.
  rlpe_back #(
    .RESET_SLOTS (RESET_SLOTS)
  ) u_back (
    .clk             (clk),
    .rst             (rst),
    .head            (head_cmd),
    .q_empty         (q_empty),
    .pop             (q_pop),
    .zero_high_ticks (zero_high_ticks),
    .one_high_ticks  (one_high_ticks),
    .out_ch          (out_ch)
  );

`ifndef SYNTHESIS
  // A frame's final slot is always a reset slot.
  a_end_is_reset: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && out_ch.frame_end |-> out_ch.duty_ticks == '0)
    else $error("frame_end on a slot with nonzero duty");

  // The front end must never push into a full queue.
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(q_push && q_full))
    else $error("command pushed into full queue");

  // The generator only pops when the queue has something.
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    !(q_pop && q_empty))
    else $error("command popped from empty queue");

  // Nothing is offered on the output right after reset.
  a_reset_quiet: assert property (@(posedge clk)
    $past(rst) |-> !out_ch.valid)
    else $error("output valid right after reset");
`endif

endmodule

>>> src/rlpe_front.sv
// Front end: accepts LED words, tracks frame state and queues encode commands.
module rlpe_front import rlpe_pkg::*; #(
  parameter int MAX_LEDS = 64
) (
  input  logic              clk,
  input  logic              rst,
  rlpe_item_if.sink         in_ch,
  input  logic              q_full,
  output logic              push,
  output cmd_t              cmd
);

  logic              in_frame;
  logic              dropping;
  logic [LEDS_W-1:0] leds_sent;
  logic [LEDS_W:0]   leds_inc;
  logic              accept;
  logic              limit_hit;

  assign in_ch.ready = !q_full;
  assign accept      = in_ch.valid && in_ch.ready;
  assign leds_inc    = {1'b0, leds_sent} + (LEDS_W + 1)'(1);
  assign limit_hit   = leds_inc >= (LEDS_W + 1)'(MAX_LEDS);

  assign push      = accept && !dropping;
  assign cmd.word  = in_ch.led_value;
  assign cmd.lead  = !in_frame;
  assign cmd.close = in_ch.last_led || limit_hit;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_frame  <= 1'b0;
      dropping  <= 1'b0;
      leds_sent <= '0;
    end else if (accept) begin
      if (dropping) begin
        if (in_ch.last_led) begin
          dropping  <= 1'b0;
          in_frame  <= 1'b0;
          leds_sent <= '0;
        end
      end else if (in_ch.last_led || limit_hit) begin
        in_frame  <= 1'b0;
        leds_sent <= '0;
        dropping  <= !in_ch.last_led;
      end else begin
        in_frame  <= 1'b1;
        leds_sent <= leds_inc[LEDS_W-1:0];
      end
    end
  end

endmodule

>>> src/rlpe_queue.sv
// Short command queue between the front end and the slot generator.
module rlpe_queue import rlpe_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_cmd,
  input  logic pop,
  output cmd_t head,
  output logic full,
  output logic empty
);

  cmd_t              entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              do_push;
  logic              do_pop;

  assign full    = count == QCNT_W'(QUEUE_DEPTH);
  assign empty   = count == '0;
  assign head    = entries[rd_ptr];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + QPTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + QCNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - QCNT_W'(1);
      end
    end
  end

endmodule

>>> src/rlpe_back.sv
// Back end: turns queued commands into one PWM slot per cycle while out_ch is not stalled.
module rlpe_back import rlpe_pkg::*; #(
  parameter int RESET_SLOTS = 20
) (
  input  logic              clk,
  input  logic              rst,
  input  cmd_t              head,
  input  logic              q_empty,
  output logic              pop,
  input  logic [TICK_W-1:0] zero_high_ticks,
  input  logic [TICK_W-1:0] one_high_ticks,
  rlpe_slot_if.source       out_ch
);

  localparam logic [CNT_W-1:0] RESET_LAST = CNT_W'(RESET_SLOTS - 1);
  localparam logic [CNT_W-1:0] BIT_LAST   = CNT_W'(BITS_PER_LED - 1);

  logic              busy;
  logic              busy_next;
  phase_t            phase;
  phase_t            phase_next;
  logic [CNT_W-1:0]  cnt;
  logic [CNT_W-1:0]  cnt_next;
  logic [WORD_W-1:0] word;
  logic [WORD_W-1:0] word_next;
  logic              close;
  logic              close_next;

  logic              out_valid;
  logic [TICK_W-1:0] duty;
  logic              frame_end;

  phase_t            e_phase;
  logic [CNT_W-1:0]  e_cnt;
  logic [WORD_W-1:0] e_word;
  logic              e_close;
  logic              adv;
  logic              emit;
  logic              cmd_done;
  logic [TICK_W-1:0] slot_duty;
  logic              slot_end;

  // When idle, the head of the queue is worked on directly so no cycle is lost.
  assign e_phase = busy ? phase : (head.lead ? PH_LEAD : PH_BITS);
  assign e_cnt   = busy ? cnt : '0;
  assign e_word  = busy ? word : head.word;
  assign e_close = busy ? close : head.close;

  assign adv  = !out_valid || out_ch.ready;
  assign emit = adv && (busy || !q_empty);
  assign pop  = emit && (!busy || (cmd_done && !q_empty));

  always_comb begin
    slot_duty = '0;
    slot_end  = 1'b0;
    cmd_done  = 1'b0;
    case (e_phase)
      PH_LEAD: begin
      end
      PH_BITS: begin
        slot_duty = e_word[WORD_W-1] ? one_high_ticks : zero_high_ticks;
        cmd_done  = (e_cnt == BIT_LAST) && !e_close;
      end
      PH_TRAIL: begin
        slot_end = e_cnt == RESET_LAST;
        cmd_done = e_cnt == RESET_LAST;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    busy_next  = busy;
    phase_next = phase;
    cnt_next   = cnt;
    word_next  = word;
    close_next = close;
    if (emit) begin
      busy_next  = 1'b1;
      phase_next = e_phase;
      cnt_next   = e_cnt + CNT_W'(1);
      word_next  = e_word;
      close_next = e_close;
      case (e_phase)
        PH_LEAD: begin
          if (e_cnt == RESET_LAST) begin
            phase_next = PH_BITS;
            cnt_next   = '0;
          end
        end
        PH_BITS: begin
          word_next = {e_word[WORD_W-2:0], 1'b0};
          if (e_cnt == BIT_LAST) begin
            phase_next = PH_TRAIL;
            cnt_next   = '0;
          end
        end
        PH_TRAIL: begin
        end
        default: begin
        end
      endcase
      if (cmd_done) begin
        if (!q_empty) begin
          phase_next = head.lead ? PH_LEAD : PH_BITS;
          cnt_next   = '0;
          word_next  = head.word;
          close_next = head.close;
        end else begin
          busy_next = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      phase <= PH_LEAD;
      cnt   <= '0;
    end else begin
      busy  <= busy_next;
      phase <= phase_next;
      cnt   <= cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    word  <= word_next;
    close <= close_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      duty      <= slot_duty;
      frame_end <= slot_end;
    end
  end

  assign out_ch.valid      = out_valid;
  assign out_ch.duty_ticks = duty;
  assign out_ch.frame_end  = frame_end;

endmodule
